// ===== sv/countdown_timer_with_blink_alarm_unit_assert.svh =====
`ifndef COUNTDOWN_TIMER_WITH_BLINK_ALARM_UNIT_ASSERT_SVH
`define COUNTDOWN_TIMER_WITH_BLINK_ALARM_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CTBU_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ctbu: check failed");

// next-cycle implication, checked out of reset
`define CTBU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ctbu: check failed");

`endif

// ===== sv/ctbu_pkg.sv =====
package ctbu_pkg;

  localparam int unsigned PRESET_W   = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned ELAPSED_W  = 16;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd500;

  // func codes
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_RESET = 2'd2;

  // reported run state
  localparam logic [1:0] RS_IDLE  = 2'd0;
  localparam logic [1:0] RS_RUN   = 2'd1;
  localparam logic [1:0] RS_PAUSE = 2'd2;
  localparam logic [1:0] RS_DONE  = 2'd3;

  // status codes
  localparam logic [2:0] ST_UNSET  = 3'd0;
  localparam logic [2:0] ST_READY  = 3'd1;
  localparam logic [2:0] ST_COUNT  = 3'd2;
  localparam logic [2:0] ST_PAUSED = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  // configuration register indexes
  localparam logic CFG_PRESET   = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_RUN   = 4'b0010,
    PH_PAUSE = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } ctbu_in_t;

  typedef struct packed {
    logic [1:0]          run_state;
    logic [PRESET_W-1:0] shown_ms;
    logic                editable;
    logic                alarm_lit;
    logic                just_finished;
    logic [2:0]          status_code;
  } ctbu_out_t;

  typedef struct packed {
    logic [PRESET_W-1:0]   preset_ms;
    logic [INTERVAL_W-1:0] blink_period;
  } ctbu_cfg_t;

  typedef struct packed {
    phase_t                phase;
    logic [PRESET_W-1:0]   remaining;
    logic [INTERVAL_W-1:0] blink_count;
    logic                  lit;
  } ctbu_state_t;

endpackage

// ===== sv/ctbu_cfg_regs.sv =====
module ctbu_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [31:0]        wr_data,
  output ctbu_pkg::ctbu_cfg_t cfg
);
  import ctbu_pkg::*;

  ctbu_cfg_t cfg_r;
  ctbu_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        CFG_PRESET:   cfg_nxt.preset_ms = wr_data[PRESET_W-1:0];
        CFG_INTERVAL: cfg_nxt.blink_period = wr_data[INTERVAL_W-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preset_ms    <= '0;
      cfg_r.blink_period <= INTERVAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/ctbu_step.sv =====
module ctbu_step (
  input  ctbu_pkg::ctbu_state_t st,
  input  ctbu_pkg::ctbu_in_t    item,
  input  ctbu_pkg::ctbu_cfg_t   cfg,
  output ctbu_pkg::ctbu_state_t st_nxt,
  output ctbu_pkg::ctbu_out_t   res
);
  import ctbu_pkg::*;

  logic [INTERVAL_W:0] blink_sum;
  logic                reached;
  logic                fin;

  // 17-bit sum so the compare never sees a wrap
  assign blink_sum = {1'b0, st.blink_count} + {1'b0, item.elapsed_ms};
  assign reached   = {{(PRESET_W-ELAPSED_W){1'b0}}, item.elapsed_ms} >= st.remaining;

  always_comb begin
    st_nxt = st;
    fin    = 1'b0;
    case (item.func)
      FUNC_TICK: begin
        case (st.phase)
          PH_RUN: begin
            if (reached) begin
              st_nxt.remaining   = '0;
              st_nxt.phase       = PH_DONE;
              st_nxt.lit         = 1'b1;
              st_nxt.blink_count = '0;
              fin                = 1'b1;
            end else begin
              st_nxt.remaining = st.remaining -
                                 {{(PRESET_W-ELAPSED_W){1'b0}}, item.elapsed_ms};
            end
          end
          PH_DONE: begin
            if (blink_sum >= {1'b0, cfg.blink_period}) begin
              st_nxt.lit         = ~st.lit;
              st_nxt.blink_count = '0;
            end else begin
              st_nxt.blink_count = blink_sum[INTERVAL_W-1:0];
            end
          end
          default: st_nxt = st;
        endcase
      end
      FUNC_START: begin
        case (st.phase)
          PH_IDLE: begin
            if (cfg.preset_ms != '0) begin
              st_nxt.remaining = cfg.preset_ms;
              st_nxt.phase     = PH_RUN;
            end
          end
          PH_RUN:   st_nxt.phase = PH_PAUSE;
          PH_PAUSE: st_nxt.phase = PH_RUN;
          default: begin
            st_nxt.remaining = cfg.preset_ms;
            st_nxt.phase     = PH_RUN;
          end
        endcase
      end
      FUNC_RESET: begin
        st_nxt.phase     = PH_IDLE;
        st_nxt.remaining = cfg.preset_ms;
      end
      default: st_nxt = st;
    endcase
  end

  always_comb begin
    res.just_finished = fin;
    res.shown_ms      = st_nxt.remaining;
    res.editable      = 1'b0;
    res.alarm_lit     = 1'b0;
    case (st_nxt.phase)
      PH_IDLE: begin
        res.run_state   = RS_IDLE;
        res.shown_ms    = cfg.preset_ms;
        res.editable    = 1'b1;
        res.status_code = (cfg.preset_ms == '0) ? ST_UNSET : ST_READY;
      end
      PH_RUN: begin
        res.run_state   = RS_RUN;
        res.status_code = ST_COUNT;
      end
      PH_PAUSE: begin
        res.run_state   = RS_PAUSE;
        res.status_code = ST_PAUSED;
      end
      default: begin
        res.run_state   = RS_DONE;
        res.alarm_lit   = st_nxt.lit;
        res.status_code = ST_DONE;
      end
    endcase
  end

endmodule

// ===== sv/countdown_timer_with_blink_alarm_unit.sv =====
// channel  | handshake           | payload
// ---------+---------------------+--------------------------------------
// in_      | in_valid / in_stall | in_item  (func, elapsed_ms)
// out_     | out_valid/out_stall | out_res  (run_state .. status_code)
// cfg_     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// an item is registered on entry and its result is registered when the held
// item advances; one item per cycle while out_stall is low,
// set by the single state update step.
// a held result register stalls the input register, which stalls in_.
// cfg_ready is always high; reset is synchronous on rst_n.
module countdown_timer_with_blink_alarm_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ctbu_pkg::ctbu_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ctbu_pkg::ctbu_out_t out_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);
  import ctbu_pkg::*;

  ctbu_cfg_t   cfg;
  ctbu_state_t st_r;
  ctbu_state_t st_nxt;
  ctbu_in_t    item_r;
  logic        item_valid_r;
  logic        item_valid_nxt;
  ctbu_out_t   res;
  ctbu_out_t   out_res_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        advance;
  logic        in_take;

  assign cfg_ready = 1'b1;

  ctbu_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ctbu_step u_step (
    .st     (st_r),
    .item   (item_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // the held item moves on when the result register is empty or being drained
  assign advance  = item_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = item_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_take) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r & ~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r      <= 1'b0;
      out_valid_r       <= 1'b0;
      st_r.phase        <= PH_IDLE;
      st_r.remaining    <= '0;
      st_r.blink_count  <= '0;
      st_r.lit          <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_item;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`include "countdown_timer_with_blink_alarm_unit_assert.svh"

  `CTBU_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r)
  `CTBU_ASSERT_NOW(a_finish_shape, out_valid_r && out_res_r.just_finished, (out_res_r.run_state == RS_DONE) && (out_res_r.shown_ms == '0) && out_res_r.alarm_lit)
  `CTBU_ASSERT_NOW(a_editable_idle, out_valid_r, out_res_r.editable == (out_res_r.run_state == RS_IDLE))
  `CTBU_ASSERT_NOW(a_lit_only_done, out_valid_r && out_res_r.alarm_lit, out_res_r.status_code == ST_DONE)

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctbu_pkg::*;

  // func code with no meaning, the block must answer it unchanged
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 165;
  localparam int N_PHASES    = 8;

  class countdown_tracker;
    logic [31:0] preset;
    logic [15:0] interval;
    phase_t      ph;
    logic [31:0] remain;
    logic [15:0] blink_cnt;
    logic        lit;
    ctbu_out_t   awaited_shows[$];
    int          n_err;
    int          n_in;

    function new();
      preset    = '0;
      interval  = INTERVAL_RST;
      ph        = PH_IDLE;
      remain    = '0;
      blink_cnt = '0;
      lit       = 1'b0;
      n_err     = 0;
      n_in      = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == CFG_PRESET) begin
        preset = data;
      end else begin
        interval = data[15:0];
      end
    endfunction

    // advance the timer by one accepted item and queue what it must show
    function void note_item(ctbu_in_t it);
      logic [16:0] sum;
      ctbu_out_t   r;
      r = '0;
      case (it.func)
        FUNC_TICK: begin
          if (ph == PH_RUN) begin
            if ({16'd0, it.elapsed_ms} >= remain) begin
              remain          = '0;
              ph              = PH_DONE;
              lit             = 1'b1;
              blink_cnt       = '0;
              r.just_finished = 1'b1;
            end else begin
              remain = remain - {16'd0, it.elapsed_ms};
            end
          end else if (ph == PH_DONE) begin
            // formed at 17 bits so the compare sees no wrap
            sum = {1'b0, blink_cnt} + {1'b0, it.elapsed_ms};
            if (sum >= {1'b0, interval}) begin
              lit       = ~lit;
              blink_cnt = '0;
            end else begin
              blink_cnt = sum[15:0];
            end
          end
        end
        FUNC_START: begin
          case (ph)
            PH_IDLE: begin
              if (preset != '0) begin
                remain = preset;
                ph     = PH_RUN;
              end
            end
            PH_RUN:   ph = PH_PAUSE;
            PH_PAUSE: ph = PH_RUN;
            default: begin
              remain = preset;
              ph     = PH_RUN;
            end
          endcase
        end
        FUNC_RESET: begin
          ph     = PH_IDLE;
          remain = preset;
        end
        default: ;
      endcase

      case (ph)
        PH_IDLE: begin
          r.run_state   = RS_IDLE;
          r.status_code = (preset == '0) ? ST_UNSET : ST_READY;
        end
        PH_RUN: begin
          r.run_state   = RS_RUN;
          r.status_code = ST_COUNT;
        end
        PH_PAUSE: begin
          r.run_state   = RS_PAUSE;
          r.status_code = ST_PAUSED;
        end
        default: begin
          r.run_state   = RS_DONE;
          r.status_code = ST_DONE;
        end
      endcase
      r.shown_ms  = (ph == PH_IDLE) ? preset : remain;
      r.editable  = (ph == PH_IDLE);
      r.alarm_lit = (ph == PH_DONE) ? lit : 1'b0;
      awaited_shows.push_back(r);
      n_in++;
    endfunction

    function void field_ok(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        n_err++;
      end
    endfunction

    function void check_result(ctbu_out_t got);
      ctbu_out_t want;
      if (awaited_shows.size() == 0) begin
        $error("result with nothing awaited: %h", got);
        n_err++;
        return;
      end
      want = awaited_shows.pop_front();
      field_ok("run_state", 32'(want.run_state), 32'(got.run_state));
      field_ok("shown_ms", want.shown_ms, got.shown_ms);
      field_ok("editable", 32'(want.editable), 32'(got.editable));
      field_ok("alarm_lit", 32'(want.alarm_lit), 32'(got.alarm_lit));
      field_ok("just_finished", 32'(want.just_finished), 32'(got.just_finished));
      field_ok("status_code", 32'(want.status_code), 32'(got.status_code));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ctbu_in_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ctbu_out_t   out_res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  countdown_tracker tracker = new();

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int span = 300;
  bit hold_active = 1'b0;
  bit hold_done = 1'b0;
  int quiet = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  countdown_timer_with_blink_alarm_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic send_item(ctbu_in_t it);
    int gap;
    gap = 0;
    if (!hold_active && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 12);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    tracker.note_item(it);
  endtask

  task automatic press(logic [1:0] func, logic [15:0] elapsed);
    send_item('{func, elapsed});
  endtask

  task automatic load_reg(logic idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  // drain every result, then let the clock run on so nothing is still in flight
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.awaited_shows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic ctbu_in_t random_item();
    ctbu_in_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      it.func = FUNC_TICK;
    end else if (r < 86) begin
      it.func = FUNC_START;
    end else if (r < 96) begin
      it.func = FUNC_RESET;
    end else begin
      it.func = FUNC_SPARE;
    end
    case ($urandom_range(0, 9))
      0:       it.elapsed_ms = '0;
      1:       it.elapsed_ms = 16'hFFFF;
      2, 3, 4: it.elapsed_ms = 16'($urandom_range(0, 65535));
      default: it.elapsed_ms = 16'($urandom_range(1, span));
    endcase
    return it;
  endfunction

  // result side: random stall bursts plus one long hold to back the block up
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        tracker.check_result(out_res);
      end
      if (!hold_done && tracker.n_in >= 420) begin
        hold_done   = 1'b1;
        hold_active = 1'b1;
        stall_left  = HOLD_CYCLES;
      end else if (stall_left == 0 && $urandom_range(0, 99) < recv_gap_pct) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall   <= 1'b0;
        hold_active = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] pre;
    logic [15:0] ivl;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // preset still zero: start must not move, idle ticks and the spare code too
    press(FUNC_START, 16'd0);
    press(FUNC_TICK, 16'hFFFF);
    press(FUNC_SPARE, 16'h5A5A);
    press(FUNC_RESET, 16'd0);
    settle();
    load_reg(CFG_PRESET, 32'd100);
    press(FUNC_START, 16'd0);
    press(FUNC_TICK, 16'd0);
    press(FUNC_TICK, 16'd30);
    press(FUNC_START, 16'd0);
    press(FUNC_TICK, 16'hFFFF);
    press(FUNC_START, 16'd0);
    press(FUNC_TICK, 16'd70);
    press(FUNC_TICK, 16'd499);
    press(FUNC_TICK, 16'd1);
    press(FUNC_TICK, 16'hFFFF);
    press(FUNC_START, 16'd0);
    press(FUNC_TICK, 16'd101);
    press(FUNC_RESET, 16'hFFFF);
    press(FUNC_SPARE, 16'd0);
    settle();
    load_reg(CFG_PRESET, 32'hFFFF_FFFF);
    press(FUNC_START, 16'd0);
    press(FUNC_TICK, 16'hFFFF);
    // preset changed while counting: remaining stays until the next load
    settle();
    load_reg(CFG_PRESET, 32'd5);
    press(FUNC_TICK, 16'd1);
    press(FUNC_START, 16'd0);
    press(FUNC_RESET, 16'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin
          pre = 32'd1;
          ivl = 16'd0;
        end
        1: begin
          pre = 32'hFFFF_FFFF;
          ivl = 16'hFFFF;
        end
        2: begin
          pre = $urandom_range(100, 5000);
          ivl = 16'd1;
        end
        3: begin
          pre = $urandom_range(1000, 200000);
          ivl = INTERVAL_RST;
        end
        4: begin
          pre = '0;
          ivl = 16'($urandom_range(1, 65535));
        end
        5: begin
          pre = $urandom();
          ivl = 16'($urandom_range(2, 2000));
        end
        6: begin
          pre = $urandom_range(10, 3000);
          ivl = 16'($urandom_range(1, 300));
        end
        default: begin
          pre = $urandom_range(50, 2000);
          ivl = 16'($urandom_range(1, 1000));
        end
      endcase
      settle();
      load_reg(CFG_PRESET, pre);
      // upper half of the data word is junk for the interval register
      load_reg(CFG_INTERVAL, {16'($urandom()), ivl});
      span = (pre / 4 > 65535) ? 65535 : ((pre / 4 < 8) ? 8 : int'(pre / 4));
      if (p == N_PHASES - 1) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 10;
          default: send_gap_pct = 30;
        endcase
        case ($urandom_range(0, 2))
          0:       recv_gap_pct = 0;
          1:       recv_gap_pct = 10;
          default: recv_gap_pct = 30;
        endcase
      end
      repeat (PHASE_ITEMS) send_item(random_item());
    end

    in_valid <= 1'b0;
    while (tracker.awaited_shows.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (tracker.n_err == 0 && tracker.awaited_shows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/ctbu_pkg.sv
sv/ctbu_cfg_regs.sv
sv/ctbu_step.sv
sv/countdown_timer_with_blink_alarm_unit.sv
verif/tb_top.sv
